// File: design/dha_pkg.sv
// Shared types, constants and tables for the detection head activation block.
// No dependencies; imported by every module of the block.
package dha_pkg;

  // log2(e) in Q15
  localparam logic [15:0] LOG2E_Q15 = 16'd47274;
  localparam logic signed [15:0] LOGIT_MIN = 16'sh8000;
  localparam logic [12:0] ONE_Q12 = 13'd4096;

  // configuration register indexes
  localparam logic [3:0] REG_CLASS_CNT = 4'd0;
  localparam logic [3:0] REG_COORDS = 4'd1;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXP0,
    ST_EXP1,
    ST_EXP2,
    ST_DIV,
    ST_EMIT
  } back_state_e;

  // one vector handed from front to back
  typedef struct packed {
    logic              valid;
    logic [3:0]        coords;
    logic [5:0]        n_cls;
    logic signed [15:0] max_logit;
  } job_t;

  // Q16 table of 2^(-i/16)
  function automatic logic [16:0] pow2_frac(input logic [3:0] idx);
    logic [16:0] v;
    case (idx)
      4'd0:  v = 17'd65536;
      4'd1:  v = 17'd62757;
      4'd2:  v = 17'd60097;
      4'd3:  v = 17'd57549;
      4'd4:  v = 17'd55109;
      4'd5:  v = 17'd52773;
      4'd6:  v = 17'd50535;
      4'd7:  v = 17'd48393;
      4'd8:  v = 17'd46341;
      4'd9:  v = 17'd44377;
      4'd10: v = 17'd42495;
      4'd11: v = 17'd40693;
      4'd12: v = 17'd38968;
      4'd13: v = 17'd37316;
      4'd14: v = 17'd35734;
      default: v = 17'd34219;
    endcase
    return v;
  endfunction

endpackage

// File: design/detection_head_activation_unit.sv
// Top level of the detection head activation block: front, back, result queue.
// Depends on dha_pkg, dha_front, dha_back, dha_outq.
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          raw_value_i
// result    out        empty / pop          out_value_o, last_out_o
// config    in         cfg_valid_i/ready_o  cfg_index_i, cfg_data_i
//
// A vector of L = coords + 1 + class-count items is taken one per cycle while full
// is low, then the back end runs: first one exponential per class, then each result
// (passthrough, softmax or sigmoid), softmax and sigmoid results going through the
// shared one-bit-per-cycle divider; a full result queue holds the back end in its emit
// step. full stays high from the last item of a vector until its last result
// enters the result queue, and while a config transaction is offered.
// Reset clears all control state.
module detection_head_activation_unit import dha_pkg::*; #(
  parameter int MAX_CLASSES = 32,
  parameter int MAX_COORDS  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] raw_value_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_value_o,
  output logic               last_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  localparam int DEPTH = MAX_COORDS + 1 + MAX_CLASSES;
  localparam int AW    = $clog2(DEPTH);

  job_t          job;
  logic          job_take, back_busy, wr_en, oq_wr, oq_full;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [16:0]   oq_wdata, oq_rdata;

  dha_front #(.MAX_CLASSES(MAX_CLASSES), .MAX_COORDS(MAX_COORDS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .raw_value_i (raw_value_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .back_busy_i (back_busy),
    .job_take_i  (job_take),
    .job_o       (job),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  dha_back #(.MAX_CLASSES(MAX_CLASSES), .MAX_COORDS(MAX_COORDS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (job),
    .job_take_o (job_take),
    .busy_o     (back_busy),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .oq_full_i  (oq_full),
    .oq_wr_o    (oq_wr),
    .oq_data_o  (oq_wdata)
  );

  dha_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (oq_wr),
    .wr_data_i (oq_wdata),
    .full_o    (oq_full),
    .pop       (pop),
    .empty     (empty),
    .rd_data_o (oq_rdata)
  );

  assign out_value_o = oq_rdata[15:0];
  assign last_out_o  = oq_rdata[16];

endmodule

// File: design/dha_front.sv
// Front end: input transactions, config registers, class maximum, job issue.
// Depends on dha_pkg.
module dha_front import dha_pkg::*; #(
  parameter int MAX_CLASSES = 32,
  parameter int MAX_COORDS  = 8,
  parameter int DEPTH       = MAX_COORDS + 1 + MAX_CLASSES,
  parameter int AW          = $clog2(DEPTH),
  parameter int LEN_W       = $clog2(DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] raw_value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               back_busy_i,
  input  logic               job_take_i,
  output job_t               job_o,
  output logic               wr_en_o,
  output logic [AW-1:0]      wr_addr_o,
  output logic [15:0]        wr_data_o
);

  logic [5:0]         ncls_q, nc_clamp;
  logic [3:0]         coords_q, co_clamp;
  logic [LEN_W-1:0]   pos_q, len;
  logic signed [15:0] max_q, max_new;
  job_t               job_q;
  logic               accept, cfg_we;

  // input stalls while a config transaction is offered
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign full        = job_q.valid | back_busy_i | cfg_valid_i;
  assign accept      = push & ~full;
  assign len = LEN_W'(coords_q) + LEN_W'(1) + LEN_W'(ncls_q);

  // register clamping
  always_comb begin
    nc_clamp = cfg_data_i[5:0];
    if (nc_clamp == 6'd0) nc_clamp = 6'd1;
    else if (int'(nc_clamp) > MAX_CLASSES) nc_clamp = 6'(MAX_CLASSES);
    co_clamp = cfg_data_i[3:0];
    if (co_clamp < 4'd2) co_clamp = 4'd2;
    else if (int'(co_clamp) > MAX_COORDS) co_clamp = 4'(MAX_COORDS);
  end

  // running maximum over class scores
  always_comb begin
    max_new = max_q;
    if (pos_q > LEN_W'(coords_q) && raw_value_i > max_q) max_new = raw_value_i;
  end

  assign wr_en_o   = accept;
  assign wr_addr_o = pos_q[AW-1:0];
  assign wr_data_o = raw_value_i;
  assign job_o     = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncls_q   <= 6'd20;
      coords_q <= 4'd4;
      pos_q    <= '0;
      max_q    <= LOGIT_MIN;
      job_q    <= '0;
    end else begin
      if (job_take_i) job_q.valid <= 1'b0;
      if (cfg_we) begin
        if (cfg_index_i == REG_CLASS_CNT) begin
          ncls_q <= nc_clamp;
          pos_q  <= '0;
          max_q  <= LOGIT_MIN;
        end else if (cfg_index_i == REG_COORDS) begin
          coords_q <= co_clamp;
          pos_q    <= '0;
          max_q    <= LOGIT_MIN;
        end
      end else if (accept) begin
        if (pos_q == len - LEN_W'(1)) begin
          pos_q <= '0;
          max_q <= LOGIT_MIN;
          job_q <= '{valid: 1'b1, coords: coords_q, n_cls: ncls_q,
                     max_logit: max_new};
        end else begin
          pos_q <= pos_q + LEN_W'(1);
          max_q <= max_new;
        end
      end
    end
  end

endmodule

// File: design/dha_div.sv
// Restoring divider, one quotient bit per cycle, 13-bit quotient.
// Quotient is known to stay below 2^13. Depends on dha_pkg.
module dha_div import dha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [28:0] num_i,
  input  logic [17:0] den_i,
  output logic        done_o,
  output logic [12:0] quo_o
);

  logic [18:0] rem_q, rem_d, trial;
  logic [12:0] low_q, quo_q;
  logic [17:0] den_q;
  logic [3:0]  cnt_q;
  logic        busy_q, ge;

  assign trial  = {rem_q[17:0], low_q[12]};
  assign ge     = trial >= {1'b0, den_q};
  assign rem_d  = ge ? trial - {1'b0, den_q} : trial;
  assign quo_o  = quo_q;
  assign done_o = busy_q && cnt_q == 4'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 4'd13;
    end else if (busy_q) begin
      if (cnt_q == 4'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 4'd1;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {3'd0, num_i[28:13]};
      low_q <= num_i[12:0];
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q && cnt_q != 4'd0) begin
      rem_q <= rem_d;
      low_q <= {low_q[11:0], 1'b0};
      quo_q <= {quo_q[11:0], ge};
    end
  end

endmodule

// File: design/dha_outq.sv
// Two-entry result queue between the back end and the result ports.
// Depends on dha_pkg.
module dha_outq import dha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_i,
  input  logic [16:0] wr_data_i,
  output logic        full_o,
  input  logic        pop,
  output logic        empty,
  output logic [16:0] rd_data_o
);

  logic [16:0] mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        do_wr, do_rd;

  assign full_o    = cnt_q == 2'd2;
  assign empty     = cnt_q == 2'd0;
  assign do_wr     = wr_i & ~full_o;
  assign do_rd     = pop & ~empty;
  assign rd_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= ~wp_q;
      if (do_rd) rp_q <= ~rp_q;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 2'd1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// File: design/dha_back.sv
// Back end: vector store, exp pipeline steps, softmax sum and result sequencing.
// Depends on dha_pkg and dha_div.
module dha_back import dha_pkg::*; #(
  parameter int MAX_CLASSES = 32,
  parameter int MAX_COORDS  = 8,
  parameter int DEPTH       = MAX_COORDS + 1 + MAX_CLASSES,
  parameter int AW          = $clog2(DEPTH),
  parameter int LEN_W       = $clog2(DEPTH + 1),
  parameter int CLS_AW      = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  job_t          job_i,
  output logic          job_take_o,
  output logic          busy_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [15:0]   wr_data_i,
  input  logic          oq_full_i,
  output logic          oq_wr_o,
  output logic [16:0]   oq_data_o
);

  back_state_e state_q, state_d;

  logic [15:0]        vmem [DEPTH];
  logic [12:0]        emem [MAX_CLASSES];
  logic signed [15:0] vrd_q;
  logic [12:0]        erd_q;
  logic [AW-1:0]      vaddr;
  logic [CLS_AW-1:0]  eaddr;

  logic               pass_q;
  logic [LEN_W-1:0]   idx_q, len_q;
  logic [3:0]         coords_q;
  logic [5:0]         nc_q;
  logic signed [15:0] max_q;
  logic [17:0]        sum_q;
  logic               xneg_q;
  logic [16:0]        u_q, val_q;
  logic [4:0]         k_q;
  logic [15:0]        res_q;

  logic               is_sig, is_pass, last_idx;
  logic [15:0]        t;
  logic [31:0]        prod;
  logic [16:0]        a, b, e;
  logic [19:0]        dmul;
  logic [17:0]        e_rnd;
  logic [17:0]        dsig;
  logic               div_start, div_done;
  logic [28:0]        div_num;
  logic [17:0]        div_den;
  logic [12:0]        quo;

  // element kind of the current output position
  assign is_sig   = idx_q < LEN_W'(2) || idx_q == LEN_W'(coords_q);
  assign is_pass  = idx_q < LEN_W'(coords_q);
  assign last_idx = pass_q ? (idx_q == len_q - LEN_W'(1))
                           : (idx_q == LEN_W'(nc_q) - LEN_W'(1));

  // store addresses
  assign vaddr = pass_q ? idx_q[AW-1:0]
                        : AW'(idx_q + LEN_W'(coords_q) + LEN_W'(1));
  assign eaddr = CLS_AW'(idx_q - LEN_W'(coords_q) - LEN_W'(1));

  // vector store: front writes, back reads
  always_ff @(posedge clk_i) begin
    if (wr_en_i) vmem[wr_addr_i] <= wr_data_i;
    vrd_q <= vmem[vaddr];
  end

  // class exponential store
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EXP2 && !pass_q) emem[idx_q[CLS_AW-1:0]] <= e_rnd[12:0];
    erd_q <= emem[eaddr];
  end

  // exp step 0: argument and log2(e) scaling
  always_comb begin
    if (pass_q) t = vrd_q[15] ? 16'(-vrd_q) : vrd_q;
    else t = 16'(max_q - vrd_q);
    prod = 32'(t) * 32'(LOG2E_Q15);
  end

  // exp step 1: table lookup and interpolation
  always_comb begin
    a    = pow2_frac(u_q[11:8]);
    b    = (u_q[11:8] == 4'd15) ? 17'd32768 : pow2_frac(u_q[11:8] + 4'd1);
    dmul = 20'(a - b) * 20'(u_q[7:0]);
  end

  // exp step 2: integer shift and rounding to Q12
  assign e     = val_q >> k_q;
  assign e_rnd = (18'(e) + 18'd8) >> 4;
  assign dsig  = 18'd65536 + 18'(e);

  // divider launch
  always_comb begin
    div_start = 1'b0;
    div_num   = 29'(erd_q) * 29'd4096 + 29'(sum_q >> 1);
    div_den   = sum_q;
    if (state_q == ST_EXP0 && pass_q && !is_sig && !is_pass) div_start = 1'b1;
    if (state_q == ST_EXP2 && pass_q) begin
      div_start = 1'b1;
      div_num   = 29'h1000_0000 + 29'(dsig >> 1);
      div_den   = dsig;
    end
  end

  dha_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (job_i.valid) state_d = ST_READ;
      ST_READ: state_d = ST_EXP0;
      ST_EXP0: begin
        if (pass_q && !is_sig) state_d = is_pass ? ST_EMIT : ST_DIV;
        else state_d = ST_EXP1;
      end
      ST_EXP1: state_d = ST_EXP2;
      ST_EXP2: state_d = pass_q ? ST_DIV : ST_READ;
      ST_DIV:  if (div_done) state_d = ST_EMIT;
      ST_EMIT: if (!oq_full_i) state_d = last_idx ? ST_IDLE : ST_READ;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    job_take_o = state_q == ST_IDLE && job_i.valid;
    busy_o     = state_q != ST_IDLE;
    oq_wr_o    = state_q == ST_EMIT;
    oq_data_o  = {last_idx, res_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && job_i.valid) begin
        pass_q <= 1'b0;
        idx_q  <= '0;
      end else if (state_q == ST_EXP2 && !pass_q) begin
        if (last_idx) begin
          pass_q <= 1'b1;
          idx_q  <= '0;
        end else begin
          idx_q <= idx_q + LEN_W'(1);
        end
      end else if (state_q == ST_EMIT && !oq_full_i) begin
        idx_q <= idx_q + LEN_W'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        coords_q <= job_i.coords;
        nc_q     <= job_i.n_cls;
        max_q    <= job_i.max_logit;
        len_q    <= LEN_W'(job_i.coords) + LEN_W'(1) + LEN_W'(job_i.n_cls);
        sum_q    <= '0;
      end
      ST_EXP0: begin
        u_q    <= prod[31:15];
        xneg_q <= vrd_q[15];
        res_q  <= vrd_q;
      end
      ST_EXP1: begin
        val_q <= a - 17'(dmul >> 8);
        k_q   <= u_q[16:12];
      end
      ST_EXP2: if (!pass_q) sum_q <= sum_q + e_rnd;
      ST_DIV: begin
        if (div_done) begin
          if (is_sig && xneg_q) res_q <= 16'(ONE_Q12 - quo);
          else res_q <= 16'(quo);
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/dha_checker.sv
// Port-level checks for the detection head activation block, bound to the top.
// Depends on detection_head_activation_unit.
module dha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        push,
  input logic        full,
  input logic [15:0] raw_value_i,
  input logic        empty,
  input logic        pop,
  input logic [15:0] out_value_o,
  input logic        last_out_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [3:0]  cfg_index_i,
  input logic [7:0]  cfg_data_i
);

  // a waiting result stays until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty) else $error("result dropped without pop");

  // a stalled result keeps its payload
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> ($stable(out_value_o) && $stable(last_out_o)))
    else $error("stalled result changed");

  // config channel never back-pressures
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o) else $error("config write stalled");

  // leaving reset the block is open for input and holds no result
  a_rst: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (!full && empty)) else $error("bad state after reset");

endmodule

bind detection_head_activation_unit dha_checker u_dha_checker (.*);

// File: sim/detection_head_activation_unit_tb.sv
// Self-checking testbench for detection_head_activation_unit: random and directed
// cell vectors, config changes, idle/stall phases. Depends on dha_pkg and the RTL.
`timescale 1ns / 100ps

module detection_head_activation_unit_tb;
  import dha_pkg::*;

  typedef struct {
    logic signed [15:0] value;
    logic               last;
  } act_out_t;

  // Cell activation predictor with its own copy of state and config
  class cell_activation_model;
    int unsigned pow2_q16[16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                                  46341, 44377, 42495, 40693, 38968, 37316, 35734, 34219};
    int unsigned n_classes;
    int unsigned n_coords;
    int          cell_vals[41];
    int unsigned fill_pos;
    int          peak_logit;
    int unsigned exp_total;
    act_out_t    pending_outs[$];
    int          mismatches;

    function new();
      n_classes = 20;
      n_coords  = 4;
      restart();
      mismatches = 0;
    endfunction

    function void restart();
      fill_pos   = 0;
      peak_logit = -32768;
      exp_total  = 0;
    endfunction

    function void write_reg(logic [3:0] idx, logic [7:0] data);
      int unsigned v;
      if (idx == REG_CLASS_CNT) begin
        v = data & 8'h3f;
        n_classes = (v < 1) ? 1 : (v > 32) ? 32 : v;
        restart();
      end else if (idx == REG_COORDS) begin
        v = data & 8'h0f;
        n_coords = (v < 2) ? 2 : (v > 8) ? 8 : v;
        restart();
      end
    endfunction

    function int unsigned exp_neg_q16(int unsigned t);
      longint unsigned u, a, b, val;
      int unsigned k, f, idx, frac;
      u    = (longint'(t) * 47274) >> 15;
      k    = u >> 12;
      f    = u & 4095;
      idx  = f >> 8;
      frac = f & 255;
      a    = pow2_q16[idx];
      b    = (idx < 15) ? pow2_q16[idx + 1] : 32768;
      val  = a - (((a - b) * frac) >> 8);
      return (k >= 32) ? 0 : int'(val >> k);
    endfunction

    function int sigmoid_q12(int x);
      longint unsigned d, s;
      d = 65536 + exp_neg_q16((x < 0) ? -x : x);
      s = ((64'd1 << 28) + (d >> 1)) / d;
      return (x < 0) ? 4096 - int'(s) : int'(s);
    endfunction

    // Accepted input transaction
    function void note_input(logic signed [15:0] raw);
      int unsigned len, e12[32], s;
      int r;
      act_out_t o;
      len = n_coords + 1 + n_classes;
      if (fill_pos >= len) fill_pos = 0;
      cell_vals[fill_pos] = raw;
      if (fill_pos > n_coords && raw > peak_logit) peak_logit = raw;
      fill_pos++;
      if (fill_pos < len) return;
      exp_total = 0;
      for (int i = 0; i < n_classes; i++) begin
        e12[i] = (exp_neg_q16((peak_logit - cell_vals[n_coords + 1 + i]) & 16'hffff) + 8) >> 4;
        exp_total = (exp_total + e12[i]) & 18'h3ffff;
      end
      s = (exp_total != 0) ? exp_total : 1;
      for (int i = 0; i < len; i++) begin
        if (i < 2 || i == n_coords) r = sigmoid_q12(cell_vals[i]);
        else if (i < n_coords) r = cell_vals[i];
        else r = int'((longint'(e12[i - n_coords - 1]) * 4096 + (s >> 1)) / s);
        o.value = r[15:0];
        o.last  = (i + 1 == len);
        pending_outs.insert(pending_outs.size(), o);
      end
      fill_pos   = 0;
      peak_logit = -32768;
    endfunction

    // Accepted result transaction
    function void check_result(logic signed [15:0] value, logic last);
      act_out_t exp_o;
      if (pending_outs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: value %0d last %0b", value, last);
        return;
      end
      exp_o = pending_outs.pop_front();
      if (value !== exp_o.value || last !== exp_o.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected value %0d last %0b, got value %0d last %0b",
                   exp_o.value, exp_o.last, value, last);
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] raw_value_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] out_value_o;
  logic               last_out_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [3:0]         cfg_index_i = '0;
  logic [7:0]         cfg_data_i = '0;

  int unsigned snd_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  cell_activation_model model = new();

  detection_head_activation_unit i_dut (.*);

  always #5 clk_i = ~clk_i;

  // Monitor: sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) model.note_input(raw_value_i);
    if (rst_ni && pop && !empty) model.check_result(out_value_o, last_out_o);
  end

  // Receiver with random stalls
  always @(negedge clk_i) pop <= ($urandom_range(99) >= rcv_stall_pct);

  task automatic send_value(logic signed [15:0] v);
    while ($urandom_range(99) < snd_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push        = 1'b1;
    raw_value_i = v;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
    push = 1'b0;
  endtask

  task automatic drain_results();
    while (model.pending_outs.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
  endtask

  task automatic write_cfg(logic [3:0] idx, logic [7:0] data);
    drain_results();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    model.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic signed [15:0] rand_logit();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(16384)) - 16'sd8192;
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return 16'($urandom_range(2048)) - 16'sd1024;
    endcase
  endfunction

  task automatic send_cell();
    int unsigned len;
    len = model.n_coords + 1 + model.n_classes;
    for (int i = 0; i < len; i++) send_value(rand_logit());
  endtask

  initial begin
    int unsigned sent;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset config, field extremes
    send_value(16'sh7fff); send_value(16'sh8000); send_value(16'sh0001); send_value(-16'sd1);
    send_value(16'sh8000);
    for (int i = 0; i < 20; i++) send_value(i[0] ? 16'sh7fff : 16'sh8000);
    // clamp low, then clamp high
    write_cfg(REG_CLASS_CNT, 8'd0);
    write_cfg(REG_COORDS, 8'd0);
    send_value(16'sh7fff); send_value(16'sh8000); send_value(16'sh0000); send_value(16'sh1234);
    write_cfg(REG_CLASS_CNT, 8'hff);
    write_cfg(REG_COORDS, 8'hff);
    send_cell();
    // unknown index ignored, partial vector dropped by a write
    write_cfg(4'd2, 8'd5);
    write_cfg(4'd15, 8'd3);
    send_value(16'sh0100); send_value(16'sh0200); send_value(16'sh0300);
    write_cfg(REG_COORDS, 8'd3);
    write_cfg(REG_CLASS_CNT, 8'd2);
    send_cell();

    // Random phases across idle modes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 69; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 69; end
        default: begin snd_idle_pct = 14; rcv_stall_pct = 14; end
      endcase
      write_cfg(REG_CLASS_CNT, (ph == 7) ? 8'd32 : 8'($urandom_range(1, 12)));
      write_cfg(REG_COORDS, (ph == 6) ? 8'd2 : 8'($urandom_range(2, 8)));
      sent = 0;
      while (sent < 50) begin
        send_cell();
        sent += model.n_coords + 1 + model.n_classes;
        if (ph == 3 && sent < 50) drain_results();
      end
      // occasional trailing partial vector
      if ($urandom_range(1)) send_value(16'($urandom));
    end

    drain_results();
    if (model.mismatches == 0 && model.pending_outs.size() == 0)
      $display("detection_head_activation_unit regression: pass");
    else
      $display("detection_head_activation_unit regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("detection_head_activation_unit regression: fail");
    $finish;
  end

endmodule
